// File: hdl/assert_macros.svh
// assertion helpers for the rtl top
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property checked on the rising clock, quiet while reset is held
`define BDQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// same-cycle implication
`define BDQ_ASSERT_IMP(lbl, ante, cons, msg) \
	`BDQ_ASSERT(lbl, (ante) |-> (cons), msg)

// next-cycle implication
`define BDQ_ASSERT_NXT(lbl, ante, cons, msg) \
	`BDQ_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// File: hdl/bdq_pkg.sv
package bdq_pkg;

	localparam int DEPTH     = 256;
	localparam int ELEM_BITS = 32;
	localparam int PTR_W     = $clog2(DEPTH);
	localparam int CNT_W     = $clog2(DEPTH + 1);

	typedef enum logic [2:0] {
		REQ_INS_HEAD = 3'd0,
		REQ_INS_TAIL = 3'd1,
		REQ_REM_HEAD = 3'd2,
		REQ_REM_TAIL = 3'd3,
		REQ_RD_HEAD  = 3'd4,
		REQ_RD_TAIL  = 3'd5,
		REQ_RD_IDX   = 3'd6
	} req_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// what the control side hands to the result stage for one word
	typedef struct packed {
		logic             rd_ok;
		status_t          status;
		logic [CNT_W-1:0] count;
	} resp_t;

endpackage

// File: hdl/bdq_ram.sv
module bdq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end else if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

// File: hdl/bdq_ctrl.sv
module bdq_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [2:0]                    req_type,
	input  logic [31:0]                   elem_data,
	input  logic [7:0]                    position,
	output logic                          ram_we,
	output logic                          ram_re,
	output logic [bdq_pkg::PTR_W-1:0]     ram_addr,
	output logic [bdq_pkg::ELEM_BITS-1:0] ram_wdata,
	output bdq_pkg::resp_t                resp
);
	import bdq_pkg::*;

	logic [PTR_W-1:0] head_q, head_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [PTR_W-1:0] head_dec, head_inc, slot;
	logic [CNT_W-1:0] offset;
	logic [CNT_W:0]   sum;
	logic             empty, full, we, re;
	status_t          st;
	req_t             req;

	assign req   = req_t'(req_type);
	assign empty = (count_q == '0);
	assign full  = (count_q == CNT_W'(DEPTH));

	assign head_dec = (head_q == '0) ? PTR_W'(DEPTH - 1) : head_q - PTR_W'(1);
	assign head_inc = (head_q == PTR_W'(DEPTH - 1)) ? '0 : head_q + PTR_W'(1);

	// offset from head; for reads only meaningful when below the count
	always_comb begin
		case (req)
			REQ_INS_TAIL: offset = count_q;
			REQ_RD_TAIL:  offset = count_q - CNT_W'(1);
			REQ_RD_IDX:   offset = CNT_W'(position);
			default:      offset = '0;
		endcase
	end

	// physical slot, sum stays below twice the depth whenever the offset is meaningful
	assign sum  = {1'b0, CNT_W'(head_q)} + {1'b0, offset};
	assign slot = (sum >= (CNT_W + 1)'(DEPTH)) ? PTR_W'(sum - (CNT_W + 1)'(DEPTH))
	                                           : PTR_W'(sum);

	always_comb begin
		head_d   = head_q;
		count_d  = count_q;
		we       = 1'b0;
		re       = 1'b0;
		st       = ST_DONE;
		ram_addr = slot;
		case (req)
			REQ_INS_HEAD: begin
				if (full) begin
					st = ST_FULL;
				end else begin
					we       = 1'b1;
					ram_addr = head_dec;
					head_d   = head_dec;
					count_d  = count_q + CNT_W'(1);
				end
			end
			REQ_INS_TAIL: begin
				if (full) begin
					st = ST_FULL;
				end else begin
					we      = 1'b1;
					count_d = count_q + CNT_W'(1);
				end
			end
			REQ_REM_HEAD: begin
				if (empty) begin
					st = ST_EMPTY;
				end else begin
					head_d  = head_inc;
					count_d = count_q - CNT_W'(1);
				end
			end
			REQ_REM_TAIL: begin
				if (empty) begin
					st = ST_EMPTY;
				end else begin
					count_d = count_q - CNT_W'(1);
				end
			end
			REQ_RD_HEAD, REQ_RD_TAIL: begin
				if (empty) begin
					st = ST_EMPTY;
				end else begin
					re = 1'b1;
				end
			end
			REQ_RD_IDX: begin
				if (32'(position) >= 32'(count_q)) begin
					st = ST_EMPTY;
				end else begin
					re = 1'b1;
				end
			end
			default: begin
				st = ST_EMPTY;
			end
		endcase
	end

	assign ram_we      = start & we;
	assign ram_re      = start & re;
	assign ram_wdata   = ELEM_BITS'(elem_data);
	assign resp.rd_ok  = re;
	assign resp.status = st;
	assign resp.count  = start ? count_d : count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else if (start) begin
			head_q  <= head_d;
			count_q <= count_d;
		end
	end

endmodule

// File: hdl/bounded_deque_with_indexed_read_top.sv
// channel   ports                                   handshake
// -------   -------------------------------------   ---------------------------
// request   req_type, elem_data, position           start high while busy low
// result    read_data, status, count                done high for one cycle
//
// one word accepted every cycle; busy never rises
// result shows in the cycle after its request, the registered ring buffer ram read sets that
// head pointer and count clear on reset, the element ram is not cleared
// the receiver cannot stall, so a result is never held back
`include "assert_macros.svh"

module bounded_deque_with_indexed_read_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  req_type,
	input  logic [31:0] elem_data,
	input  logic [7:0]  position,
	output logic        done,
	output logic [31:0] read_data,
	output logic [1:0]  status,
	output logic [8:0]  count
);
	import bdq_pkg::*;

	logic                 ram_we, ram_re;
	logic [PTR_W-1:0]     ram_addr;
	logic [ELEM_BITS-1:0] ram_wdata, ram_rdata;
	resp_t                resp;
	resp_t                resp_s1;
	logic                 done_s1;

	assign busy = 1'b0;

	bdq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.req_type  (req_type),
		.elem_data (elem_data),
		.position  (position),
		.ram_we    (ram_we),
		.ram_re    (ram_re),
		.ram_addr  (ram_addr),
		.ram_wdata (ram_wdata),
		.resp      (resp)
	);

	bdq_ram #(
		.WIDTH (ELEM_BITS),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.re    (ram_re),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s1 <= 1'b0;
		end else begin
			done_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			resp_s1 <= resp;
		end
	end

	assign done      = done_s1;
	assign read_data = (done_s1 && resp_s1.rd_ok) ? 32'(ram_rdata) : '0;
	assign status    = resp_s1.status;
	assign count     = 9'(resp_s1.count);

	`BDQ_ASSERT_NXT(a_word_answered, start && !busy, done, "accepted word got no result")
	`BDQ_ASSERT_IMP(a_count_bound, done, 32'(count) <= 32'(DEPTH), "count above depth")
	`BDQ_ASSERT_IMP(a_full_only_at_depth, done && status == ST_FULL,
		32'(count) == 32'(DEPTH), "full flag below depth")
	`BDQ_ASSERT_IMP(a_error_zero_data, done && status != ST_DONE, read_data == '0,
		"nonzero data on error")

endmodule

// File: dv/bdq_checker.sv
module bdq_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [2:0]  req_type,
	input  logic [31:0] elem_data,
	input  logic [7:0]  position,
	input  logic        done,
	input  logic [31:0] read_data,
	input  logic [1:0]  status,
	input  logic [8:0]  count,
	output int          errors,
	output int          pending,
	output int          full_hits,
	output int          empty_hits,
	output int          peak
);
	import bdq_pkg::*;

	typedef struct {
		logic [31:0]      read_data;
		status_t          status;
		logic [CNT_W-1:0] count;
	} word_t;

	logic [ELEM_BITS-1:0] ring [DEPTH];
	logic [PTR_W-1:0]     head = '0;
	logic [CNT_W-1:0]     fill = '0;
	word_t                expected_words [$];

	initial begin
		errors     = 0;
		full_hits  = 0;
		empty_hits = 0;
		peak       = 0;
	end

	// updates the shadow list for one request and queues the word it must answer with
	task automatic apply_request(input logic [2:0] op, input logic [31:0] d,
			input logic [7:0] p);
		word_t            w;
		logic [PTR_W-1:0] slot;
		w.read_data = '0;
		w.status    = ST_DONE;
		case (op)
			REQ_INS_HEAD: begin
				if (fill == CNT_W'(DEPTH)) begin
					w.status = ST_FULL;
				end else begin
					head       = head - PTR_W'(1);
					ring[head] = d;
					fill       = fill + CNT_W'(1);
				end
			end
			REQ_INS_TAIL: begin
				if (fill == CNT_W'(DEPTH)) begin
					w.status = ST_FULL;
				end else begin
					slot       = head + fill[PTR_W-1:0];
					ring[slot] = d;
					fill       = fill + CNT_W'(1);
				end
			end
			REQ_REM_HEAD: begin
				if (fill == '0) begin
					w.status = ST_EMPTY;
				end else begin
					head = head + PTR_W'(1);
					fill = fill - CNT_W'(1);
				end
			end
			REQ_REM_TAIL: begin
				if (fill == '0)
					w.status = ST_EMPTY;
				else
					fill = fill - CNT_W'(1);
			end
			REQ_RD_HEAD: begin
				if (fill == '0)
					w.status = ST_EMPTY;
				else
					w.read_data = ring[head];
			end
			REQ_RD_TAIL: begin
				if (fill == '0) begin
					w.status = ST_EMPTY;
				end else begin
					// wraps modulo the ring size, a full list included
					slot        = head + fill[PTR_W-1:0] - PTR_W'(1);
					w.read_data = ring[slot];
				end
			end
			REQ_RD_IDX: begin
				if ({1'b0, p} >= fill) begin
					w.status = ST_EMPTY;
				end else begin
					slot        = head + p;
					w.read_data = ring[slot];
				end
			end
			default: begin
				w.status = ST_EMPTY;
			end
		endcase
		w.count = fill;
		if (w.status == ST_FULL)
			full_hits++;
		if (w.status == ST_EMPTY)
			empty_hits++;
		if (int'(fill) > peak)
			peak = int'(fill);
		expected_words.push_back(w);
	endtask

	always @(posedge clk) begin
		word_t w;
		if (!arst_n) begin
			head = '0;
			fill = '0;
			expected_words.delete();
		end else begin
			// check before queuing, so a word can never match its own request
			if (done) begin
				if (expected_words.size() == 0) begin
					$error("result word with nothing expected");
					errors++;
				end else begin
					w = expected_words.pop_front();
					if (read_data !== w.read_data) begin
						$error("read_data: expected %h, got %h", w.read_data, read_data);
						errors++;
					end
					if (status !== w.status) begin
						$error("status: expected %0d, got %0d", w.status, status);
						errors++;
					end
					if (count !== w.count) begin
						$error("count: expected %0d, got %0d", w.count, count);
						errors++;
					end
				end
			end
			if (start && !busy)
				apply_request(req_type, elem_data, position);
		end
		pending <= expected_words.size();
	end

endmodule

// File: dv/tb.sv
module tb;
	import bdq_pkg::*;

	localparam logic [2:0] REQ_BOGUS = 3'd7;
	localparam int         STALL_LIMIT = 400;

	typedef enum {GROW, SHRINK, MIXED} mix_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [2:0]  req_type = '0;
	logic [31:0] elem_data = '0;
	logic [7:0]  position = '0;
	logic        busy;
	logic        done;
	logic [31:0] read_data;
	logic [1:0]  status;
	logic [8:0]  count;

	int errors;
	int pending;
	int full_hits;
	int empty_hits;
	int peak;
	int sent = 0;
	int idle_cycles = 0;
	bit burst = 1'b0;

	bounded_deque_with_indexed_read_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req_type  (req_type),
		.elem_data (elem_data),
		.position  (position),
		.done      (done),
		.read_data (read_data),
		.status    (status),
		.count     (count)
	);

	bdq_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.req_type   (req_type),
		.elem_data  (elem_data),
		.position   (position),
		.done       (done),
		.read_data  (read_data),
		.status     (status),
		.count      (count),
		.errors     (errors),
		.pending    (pending),
		.full_hits  (full_hits),
		.empty_hits (empty_hits),
		.peak       (peak)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// watchdog: cycles in which neither channel moves a word
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= STALL_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// present one word and hold it until accepted, then idle for the drawn gap
	task automatic issue(input logic [2:0] op, input logic [31:0] d, input logic [7:0] p);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 14);
		start     <= 1'b1;
		req_type  <= op;
		elem_data <= d;
		position  <= p;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sent++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	function automatic logic [2:0] pick_req(input mix_t mode);
		int r;
		r = $urandom_range(0, 99);
		case (mode)
			GROW: begin
				if (r < 47) return REQ_INS_HEAD;
				if (r < 96) return REQ_INS_TAIL;
				if (r < 98) return REQ_RD_IDX;
				if (r < 99) return REQ_RD_HEAD;
				return REQ_RD_TAIL;
			end
			SHRINK: begin
				if (r < 47) return REQ_REM_HEAD;
				if (r < 96) return REQ_REM_TAIL;
				if (r < 98) return REQ_RD_IDX;
				if (r < 99) return REQ_RD_HEAD;
				return REQ_RD_TAIL;
			end
			default: begin
				if (r < 2) return REQ_BOGUS;
				return 3'($urandom_range(0, 6));
			end
		endcase
	endfunction

	task automatic run_phase(input mix_t mode, input int n);
		logic [7:0] p;
		for (int i = 0; i < n; i++) begin
			if (i % 16 == 0)
				burst = ($urandom_range(0, 2) == 0);
			// half the indexed reads aim near the head, where small lists still hit
			p = $urandom_range(0, 1) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 7));
			issue(pick_req(mode), $urandom(), p);
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list: every remove and read is flagged
		issue(REQ_REM_HEAD, 32'h0, 8'h00);
		issue(REQ_REM_TAIL, 32'h0, 8'h00);
		issue(REQ_RD_HEAD, 32'h0, 8'h00);
		issue(REQ_RD_TAIL, 32'h0, 8'h00);
		issue(REQ_RD_IDX, 32'h0, 8'h00);
		issue(REQ_BOGUS, 32'hFFFF_FFFF, 8'hFF);
		// head insert from an empty ring wraps the head pointer
		issue(REQ_INS_HEAD, 32'hFFFF_FFFF, 8'hFF);
		issue(REQ_INS_TAIL, 32'h0000_0000, 8'h00);
		issue(REQ_INS_HEAD, 32'hA5A5_A5A5, 8'h00);
		issue(REQ_INS_TAIL, 32'h5A5A_5A5A, 8'h00);
		issue(REQ_RD_HEAD, 32'h0, 8'h00);
		issue(REQ_RD_TAIL, 32'h0, 8'h00);
		issue(REQ_RD_IDX, 32'h0, 8'd0);
		issue(REQ_RD_IDX, 32'h0, 8'd3);
		issue(REQ_RD_IDX, 32'h0, 8'd4);
		issue(REQ_RD_IDX, 32'h0, 8'hFF);
		issue(REQ_REM_HEAD, 32'h0, 8'h00);
		issue(REQ_REM_TAIL, 32'h0, 8'h00);
		issue(REQ_RD_HEAD, 32'h0, 8'h00);
		issue(REQ_RD_TAIL, 32'h0, 8'h00);
		issue(REQ_REM_HEAD, 32'h0, 8'h00);
		issue(REQ_REM_TAIL, 32'h0, 8'h00);
		issue(REQ_REM_HEAD, 32'h0, 8'h00);
		drain();

		// fill past capacity, churn at full, drain past empty, churn near empty
		run_phase(GROW, 300);
		run_phase(MIXED, 80);
		drain();
		run_phase(SHRINK, 300);
		run_phase(MIXED, 70);
		drain();
		repeat (4) @(posedge clk);

		$display("%0d words sent, list peaked at %0d of %0d entries", sent, peak, DEPTH);
		$display("%0d inserts refused on a full list, %0d requests flagged empty or out of range",
			full_hits, empty_hits);
		if (errors == 0 && pending == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// File: bounded_deque_with_indexed_read_top.f
+incdir+hdl
hdl/bdq_pkg.sv
hdl/bdq_ram.sv
hdl/bdq_ctrl.sv
hdl/bounded_deque_with_indexed_read_top.sv
dv/bdq_checker.sv
dv/tb.sv
